### hdl/rau_pkg.sv
// Shared types, codes and widths of the rational arithmetic unit.
`timescale 1ns / 1ps

package rau_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int KIND_W = 3;
  localparam int DATA_W = 32;
  localparam int DEN_W  = 31;
  localparam int STAT_W = 2;

  // Default signed operand width.
  localparam int WIDTH_DEFAULT = 32;

  // Operation codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_NEG  = 3'd4,
    KIND_INC  = 3'd5,
    KIND_DEC  = 3'd6,
    KIND_PASS = 3'd7
  } rau_kind_t;

  // Result status codes.
  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd2;

  // Which of the three products the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_CROSS_A = 2'd0,
    MUL_CROSS_B = 2'd1,
    MUL_DEN     = 2'd2
  } rau_mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load;
    logic         mul_en;
    rau_mul_sel_t mul_sel;
    logic         combine;
    logic         gcd_init;
    logic         gcd_step;
    logic         div_init;
    logic         div_step;
    logic         res_load;
  } rau_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

### hdl/rau_if.sv
// Request and response channel interfaces of the rational arithmetic unit.
`timescale 1ns / 1ps

interface rau_req_if import rau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] a_num;
  logic signed [DATA_W-1:0] a_den;
  logic signed [DATA_W-1:0] b_num;
  logic signed [DATA_W-1:0] b_den;

  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] res_num;
  logic [DEN_W-1:0]         res_den;
  logic [STAT_W-1:0]        status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

### hdl/rational_arithmetic_unit.sv
// Sequence: the three products on the shared multiplier, combine, zero check, binary gcd steps
// until gu is zero, the restoring divide, and the result load, which waits for a free output
// register; a zero denominator skips the gcd and the divide.
// One transaction at a time; the next is taken in the cycle after the result loads.
// A finished result waits in the output register while the next transaction is taken.
// Reset (rst, synchronous): controller returns to idle and the output register empties.
`timescale 1ns / 1ps

module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  rau_req_if.sink  req,
  rau_rsp_if.source rsp
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // Sequencing.
  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Arithmetic.
  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .stat    (stat),
    .kind    (req.kind),
    .a_num   (req.a_num),
    .a_den   (req.a_den),
    .b_num   (req.b_num),
    .b_den   (req.b_den),
    .res_num (rsp.res_num),
    .res_den (rsp.res_den),
    .status  (rsp.status)
  );

  // A successful result always has a nonzero denominator.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == STATUS_OK) |-> (rsp.res_den != '0))
    else $error("ok result with zero denominator");

  // Error results carry a zero fraction.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status != STATUS_OK) |-> (rsp.res_num == '0) && (rsp.res_den == '0))
    else $error("error result with nonzero payload");

  // Only defined status codes are delivered.
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == STATUS_OK) || (rsp.status == STATUS_ZERO_DEN) ||
                  (rsp.status == STATUS_OVERFLOW))
    else $error("undefined status code");

  // The unit is busy in the cycle after it takes a transaction.
  assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while a transaction is in progress");

endmodule

### hdl/rau_dp.sv
// Datapath: operand capture, shared multiplier, binary gcd and dual divider.
`timescale 1ns / 1ps

module rau_dp import rau_pkg::*; #(
  parameter int WIDTH = WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  rau_cmd_t                 cmd,
  output rau_stat_t                stat,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [DATA_W-1:0] a_num,
  input  logic signed [DATA_W-1:0] a_den,
  input  logic signed [DATA_W-1:0] b_num,
  input  logic signed [DATA_W-1:0] b_den,
  output logic signed [DATA_W-1:0] res_num,
  output logic [DEN_W-1:0]         res_den,
  output logic [STAT_W-1:0]        status
);

  localparam int PROD_W = 2 * WIDTH;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam logic [WIDTH-1:0]  ONE_M = WIDTH'(1);
  localparam logic [PROD_W-1:0] LIM   = PROD_W'(1) << (WIDTH - 1);

  // Captured operands in sign-magnitude form.
  rau_kind_t        op;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic             an_s, ad_s, bn_s, bd_s;

  // Products and combined numerator.
  logic [PROD_W-1:0] p0_m, p1_m, p2_m, num_m;
  logic              p0_s, p1_s, p2_s, num_s;

  // Binary gcd state.
  logic [PROD_W-1:0] gu, gv;
  logic [CNT_W-1:0]  gk;

  // Divider state, one lane for numerator and one for denominator.
  logic [PROD_W-1:0] g_div, qn, qd, remn, remd;
  logic [CNT_W-1:0]  dcnt;

  // Multiplier operands.
  logic [WIDTH-1:0]  mx_m, my_m;
  logic              mx_s, my_s, m_flip;
  logic [PROD_W-1:0] prod;
  logic              prod_s;

  // Combine and divide intermediates.
  logic [PROD_W-1:0] sum_m;
  logic              sum_s;
  logic [PROD_W:0]   shn, shd, dfn, dfd;

  // Result formation.
  logic              res_neg, res_ovf;
  logic [DATA_W-1:0] rn_ext;

  function automatic logic [WIDTH-1:0] to_mag(input logic [WIDTH-1:0] v);
    return v[WIDTH-1] ? WIDTH'(~v + ONE_M) : v;
  endfunction

  // Capture the operands when a transaction is taken.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= rau_kind_t'(kind);
      an_s <= a_num[WIDTH-1];
      ad_s <= a_den[WIDTH-1];
      bn_s <= b_num[WIDTH-1];
      bd_s <= b_den[WIDTH-1];
      an_m <= to_mag(a_num[WIDTH-1:0]);
      ad_m <= to_mag(a_den[WIDTH-1:0]);
      bn_m <= to_mag(b_num[WIDTH-1:0]);
      bd_m <= to_mag(b_den[WIDTH-1:0]);
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mx_m   = '0;
    mx_s   = 1'b0;
    my_m   = '0;
    my_s   = 1'b0;
    m_flip = 1'b0;
    case (cmd.mul_sel)
      MUL_CROSS_A: begin
        mx_m = an_m;
        mx_s = an_s;
        case (op)
          KIND_ADD, KIND_SUB, KIND_DIV: begin
            my_m = bd_m;
            my_s = bd_s;
          end
          KIND_MUL: begin
            my_m = bn_m;
            my_s = bn_s;
          end
          KIND_NEG: begin
            my_m   = ONE_M;
            m_flip = 1'b1;
          end
          default: begin
            my_m = ONE_M;
          end
        endcase
      end
      MUL_CROSS_B: begin
        case (op)
          KIND_ADD, KIND_SUB: begin
            mx_m   = bn_m;
            mx_s   = bn_s;
            my_m   = ad_m;
            my_s   = ad_s;
            m_flip = (op == KIND_SUB);
          end
          KIND_INC, KIND_DEC: begin
            mx_m   = ad_m;
            mx_s   = ad_s;
            my_m   = ONE_M;
            m_flip = (op == KIND_DEC);
          end
          default: begin
            mx_m = '0;
          end
        endcase
      end
      MUL_DEN: begin
        mx_m = ad_m;
        mx_s = ad_s;
        case (op)
          KIND_ADD, KIND_SUB, KIND_MUL: begin
            my_m = bd_m;
            my_s = bd_s;
          end
          KIND_DIV: begin
            my_m = bn_m;
            my_s = bn_s;
          end
          default: begin
            my_m = ONE_M;
          end
        endcase
      end
      default: begin
        mx_m = '0;
      end
    endcase
    prod   = PROD_W'(mx_m) * PROD_W'(my_m);
    prod_s = (prod != '0) && (mx_s ^ my_s ^ m_flip);
  end

  // Product registers.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        MUL_CROSS_A: begin
          p0_m <= prod;
          p0_s <= prod_s;
        end
        MUL_CROSS_B: begin
          p1_m <= prod;
          p1_s <= prod_s;
        end
        default: begin
          p2_m <= prod;
          p2_s <= prod_s;
        end
      endcase
    end
  end

  // Signed-magnitude sum of the two cross products.
  always_comb begin
    if (p0_s == p1_s) begin
      sum_m = p0_m + p1_m;
      sum_s = p0_s;
    end else if (p0_m >= p1_m) begin
      sum_m = p0_m - p1_m;
      sum_s = p0_s;
    end else begin
      sum_m = p1_m - p0_m;
      sum_s = p1_s;
    end
    if (sum_m == '0) begin
      sum_s = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.combine) begin
      num_m <= sum_m;
      num_s <= sum_s;
    end
  end

  // Binary gcd, one step per cycle; the gcd is gv shifted left by gk once gu is zero.
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      gu <= num_m;
      gv <= p2_m;
      gk <= '0;
    end else if (cmd.gcd_step) begin
      if (!gu[0] && !gv[0]) begin
        gu <= gu >> 1;
        gv <= gv >> 1;
        gk <= gk + CNT_W'(1);
      end else if (!gu[0]) begin
        gu <= gu >> 1;
      end else if (!gv[0]) begin
        gv <= gv >> 1;
      end else if (gu >= gv) begin
        gu <= gu - gv;
      end else begin
        gv <= gv - gu;
      end
    end
  end

  // Restoring division of numerator and denominator by the gcd, one bit per cycle.
  always_comb begin
    shn = {remn, qn[PROD_W-1]};
    shd = {remd, qd[PROD_W-1]};
    dfn = shn - {1'b0, g_div};
    dfd = shd - {1'b0, g_div};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      g_div <= gv << gk;
      qn    <= num_m;
      qd    <= p2_m;
      remn  <= '0;
      remd  <= '0;
      dcnt  <= CNT_W'(PROD_W);
    end else if (cmd.div_step) begin
      dcnt <= dcnt - CNT_W'(1);
      if (!dfn[PROD_W]) begin
        remn <= dfn[PROD_W-1:0];
        qn   <= {qn[PROD_W-2:0], 1'b1};
      end else begin
        remn <= shn[PROD_W-1:0];
        qn   <= {qn[PROD_W-2:0], 1'b0};
      end
      if (!dfd[PROD_W]) begin
        remd <= dfd[PROD_W-1:0];
        qd   <= {qd[PROD_W-2:0], 1'b1};
      end else begin
        remd <= shd[PROD_W-1:0];
        qd   <= {qd[PROD_W-2:0], 1'b0};
      end
    end
  end

  // Sign placement and range check of the reduced fraction.
  always_comb begin
    res_neg = (qn != '0) && (num_s != p2_s);
    res_ovf = (qd > LIM - PROD_W'(1)) ||
              (res_neg ? (qn > LIM) : (qn > LIM - PROD_W'(1)));
    rn_ext  = DATA_W'(qn);
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (p2_m == '0) begin
        res_num <= '0;
        res_den <= '0;
        status  <= STATUS_ZERO_DEN;
      end else if (res_ovf) begin
        res_num <= '0;
        res_den <= '0;
        status  <= STATUS_OVERFLOW;
      end else begin
        res_num <= res_neg ? -rn_ext : rn_ext;
        res_den <= DEN_W'(qd);
        status  <= STATUS_OK;
      end
    end
  end

  assign stat.den_zero = (p2_m == '0);
  assign stat.gcd_done = (gu == '0);
  assign stat.div_done = (dcnt == '0);

endmodule

### hdl/rau_ctrl.sv
// Controller state machine that sequences the rational arithmetic datapath.
`timescale 1ns / 1ps

module rau_ctrl import rau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output rau_cmd_t  cmd,
  input  rau_stat_t stat
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_DEN,
    ST_COMBINE,
    ST_ZERO_CHK,
    ST_GCD,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  // The output register can take a new result when empty or being emptied.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CROSS_A;
        state_next  = ST_MUL_B;
      end
      ST_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CROSS_B;
        state_next  = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DEN;
        state_next  = ST_COMBINE;
      end
      ST_COMBINE: begin
        cmd.combine = 1'b1;
        state_next  = ST_ZERO_CHK;
      end
      ST_ZERO_CHK: begin
        cmd.gcd_init = 1'b1;
        state_next   = stat.den_zero ? ST_FINISH : ST_GCD;
      end
      ST_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FINISH: begin
        if (slot_free) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
